// ===== sv/dpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, constants and register indexes of the debounced pulse counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

   // channel memory
   localparam int CHANNELS    = 16;
   localparam int CHANNEL_W   = 4;
   localparam int STATE_DEPTH = (CHANNELS < (1 << CHANNEL_W)) ? CHANNELS : (1 << CHANNEL_W);
   localparam int IDX_W       = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

   // field widths
   localparam int DELAY_W = 4;
   localparam int TICK_W  = 16;
   localparam int TIME_W  = 32;
   localparam int IVAL_W  = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // control port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_DELAY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_POLARITY  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REPORT_ON_CHANGE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNTER_MODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_INTERVAL    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_INTERVAL    = 3'd5;

   // commands
   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_PRIME = 1'b1;

   typedef struct packed {
      logic [DELAY_W-1:0] debounce_delay;
      logic               invert_polarity;
      logic               report_on_change;
      logic               counter_mode;
      logic [IVAL_W-1:0]  tick_interval;
      logic [IVAL_W-1:0]  time_interval;
   } cfg_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic                 command;
      logic [CHANNEL_W-1:0] channel;
      logic                 level;
      logic [TIME_W-1:0]    now_seconds;
      logic                 force_req;
      logic                 out_of_range;
   } item_type;

   typedef struct packed {
      logic               raw_level;
      logic               stable_level;
      logic [DELAY_W-1:0] settle_count;
      logic [TICK_W-1:0]  tick_total;
      logic [TICK_W-1:0]  ticks_at_report;
      logic [TIME_W-1:0]  time_at_report;
   } chan_state_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } queue_status_type;

endpackage

// ===== sv/dpc_channels_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc channel interfaces
// Poll request, poll response and register write channels.
// ----------------------------------------------------------------------------
interface dpc_req_if;
   import dpc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [CHANNEL_W-1:0] channel;
   logic                 pin_level;
   logic [TIME_W-1:0]    now_seconds;
   logic                 force_req;

   modport source (output valid, command, channel, pin_level, now_seconds, force_req,
                   input ready);
   modport sink   (input valid, command, channel, pin_level, now_seconds, force_req,
                   output ready);
endinterface

interface dpc_rsp_if;
   import dpc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel_out;
   logic                 report_now;
   logic                 debounced_level;
   logic                 level_changed;
   logic [TICK_W-1:0]    tick_count;
   logic [TICK_W-1:0]    prior_report_ticks;

   modport source (output valid, channel_out, report_now, debounced_level, level_changed,
                   tick_count, prior_report_ticks, input ready);
   modport sink   (input valid, channel_out, report_now, debounced_level, level_changed,
                   tick_count, prior_report_ticks, output ready);
endinterface

interface dpc_csr_if;
   import dpc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== sv/dpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_front
// Accepts poll transactions, applies polarity and classifies the channel.
// ----------------------------------------------------------------------------
module dpc_front (
   dpc_req_if.sink            req,
   input  logic               invert_polarity,
   output logic               push_valid,
   output dpc_pkg::item_type  push_item,
   input  logic               push_ready
);
   import dpc_pkg::*;

   // pass handshake straight to the queue
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   // classify: polarity, range check
   always_comb begin
      push_item.command      = req.command;
      push_item.channel      = req.channel;
      push_item.level        = req.pin_level ^ invert_polarity;
      push_item.now_seconds  = req.now_seconds;
      push_item.force_req    = req.force_req;
      push_item.out_of_range = (int'(req.channel) >= CHANNELS);
   end

endmodule

// ===== sv/dpc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_queue
// Short FIFO that decouples the front from the channel update stage.
// ----------------------------------------------------------------------------
module dpc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  dpc_pkg::item_type         push_item,
   output logic                      push_ready,
   output logic                      pop_valid,
   output dpc_pkg::item_type         pop_item,
   input  logic                      pop_ready,
   output dpc_pkg::queue_status_type status
);
   import dpc_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   assign status.count = count_ff;
   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

   // pointer wrap
   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else                               r = p + 1'b1;
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== sv/dpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_back
// Per-channel debounce, tick count; one state RMW per cycle unless stalled.
// ----------------------------------------------------------------------------
module dpc_back (
   input  logic              clock,
   input  logic              reset,
   input  dpc_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   input  dpc_pkg::item_type pop_item,
   output logic              pop_ready,
   dpc_rsp_if.source         rsp
);
   import dpc_pkg::*;

   chan_state_type state_ff [STATE_DEPTH];
   chan_state_type rd, wr;
   logic           wr_en;
   logic [IDX_W-1:0] idx;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] channel_ff;
   logic                 report_ff, report_in;
   logic                 level_ff, level_in;
   logic                 changed_ff, changed_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [TICK_W-1:0]    prior_ff, prior_in;

   logic              take;
   logic [DELAY_W-1:0] settle_n;
   logic              chg, tick, by_ticks, by_time;
   logic [TICK_W-1:0] tick_n, tick_gap;
   logic [TIME_W:0]   deadline;

   assign idx       = pop_item.channel[IDX_W-1:0];
   assign rd        = state_ff[idx];
   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;

   // channel update
   always_comb begin
      wr         = rd;
      wr_en      = 1'b0;
      report_in  = 1'b0;
      changed_in = 1'b0;
      level_in   = 1'b0;
      tick_in    = '0;
      prior_in   = '0;
      settle_n   = '0;
      chg        = 1'b0;
      tick       = 1'b0;
      tick_n     = rd.tick_total;
      tick_gap   = '0;
      by_ticks   = 1'b0;
      by_time    = 1'b0;
      deadline   = {1'b0, rd.time_at_report} + (TIME_W+1)'(cfg.time_interval);

      if (!pop_item.out_of_range) begin
         wr_en    = take;
         prior_in = rd.ticks_at_report;
         if (pop_item.command == CMD_PRIME) begin
            // prime: load levels, clear settle count, keep tick counters
            wr.raw_level    = pop_item.level;
            wr.stable_level = pop_item.level;
            wr.settle_count = '0;
         end else begin
            // debounce
            if (rd.raw_level == pop_item.level) begin
               settle_n = (rd.raw_level != rd.stable_level) ? rd.settle_count + 1'b1
                                                            : rd.settle_count;
            end else begin
               settle_n = '0;
            end
            wr.raw_level    = pop_item.level;
            wr.settle_count = settle_n;
            chg = (pop_item.level != rd.stable_level) && (cfg.debounce_delay <= settle_n);
            if (chg) wr.stable_level = pop_item.level;
            changed_in = chg;

            if (cfg.counter_mode) begin
               // rising edge counting and report triggers
               tick     = chg && pop_item.level;
               tick_n   = tick ? rd.tick_total + 1'b1 : rd.tick_total;
               tick_gap = tick_n - rd.ticks_at_report;
               by_ticks = tick && ((tick_n == '0) ||
                          ((cfg.tick_interval != '0) && (tick_gap >= cfg.tick_interval)));
               by_time  = (cfg.time_interval != '0) &&
                          (deadline < {1'b0, pop_item.now_seconds});
               wr.tick_total = tick_n;
               if (by_ticks || by_time) begin
                  report_in          = 1'b1;
                  wr.ticks_at_report = tick_n;
                  wr.time_at_report  = pop_item.now_seconds;
               end
            end else begin
               report_in = (chg && cfg.report_on_change) || pop_item.force_req;
            end
         end
         level_in = wr.stable_level;
         tick_in  = wr.tick_total;
      end
   end

   // channel memory, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATE_DEPTH; i++) state_ff[i] <= '0;
      end else if (wr_en) begin
         state_ff[idx] <= wr;
      end
   end

   // output register
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         channel_ff <= pop_item.channel;
         report_ff  <= report_in;
         level_ff   <= level_in;
         changed_ff <= changed_in;
         tick_ff    <= tick_in;
         prior_ff   <= prior_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.channel_out        = channel_ff;
   assign rsp.report_now         = report_ff;
   assign rsp.debounced_level    = level_ff;
   assign rsp.level_changed      = changed_ff;
   assign rsp.tick_count         = tick_ff;
   assign rsp.prior_report_ticks = prior_ff;

endmodule

// ===== sv/debounced_pulse_counter_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_pulse_counter_channels
// Multi-channel pin debouncer with rising-edge tick counting and reporting.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one poll (or prime) transaction per channel sample, valid/ready.
//   rsp  : exactly one result per request, in request order, valid/ready.
//   csr  : register writes (index, wdata); always ready, write only while
//          no transaction is outstanding.
// An accepted request is written into the queue, then read out through the
//   update stage into the response register, where its response turns valid.
// Throughput: one transaction per cycle unless the receiver stalls; the limit
//   is the read-modify-write of the channel state in the update stage.
// A two-entry queue separates the request side from the update stage, and
//   the response register holds a result while the receiver stalls; the
//   request side keeps accepting until the queue fills.
// Reset: synchronous; clears config, queue pointers, response valid and all
//   channel state entries in the same cycle; ready on the cycle after reset.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_channels (
   input logic       clock,
   input logic       reset,
   dpc_req_if.sink   req,
   dpc_rsp_if.source rsp,
   dpc_csr_if.sink   csr
);
   import dpc_pkg::*;

   cfg_type          cfg_ff;
   logic             push_valid, push_ready;
   item_type         push_item;
   logic             pop_valid, pop_ready;
   item_type         pop_item;
   queue_status_type q_stat;

   // register file
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            REG_DEBOUNCE_DELAY:   cfg_ff.debounce_delay   <= csr.wdata[DELAY_W-1:0];
            REG_INVERT_POLARITY:  cfg_ff.invert_polarity  <= csr.wdata[0];
            REG_REPORT_ON_CHANGE: cfg_ff.report_on_change <= csr.wdata[0];
            REG_COUNTER_MODE:     cfg_ff.counter_mode     <= csr.wdata[0];
            REG_TICK_INTERVAL:    cfg_ff.tick_interval    <= csr.wdata[IVAL_W-1:0];
            REG_TIME_INTERVAL:    cfg_ff.time_interval    <= csr.wdata[IVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dpc_front u_front (
      .req             (req),
      .invert_polarity (cfg_ff.invert_polarity),
      .push_valid      (push_valid),
      .push_item       (push_item),
      .push_ready      (push_ready)
   );

   dpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .status     (q_stat)
   );

   dpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // a request into an empty block comes out through the queue and response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && q_stat.empty && !rsp.valid) |=> ##1 rsp.valid)
      else $error("response not valid two cycles after request into empty block");

   // requests are refused only when the queue is full
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> q_stat.full)
      else $error("request side stalled with room in the queue");

   // no response straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response valid right after reset");
`endif

endmodule
